/* src/ptc_pkg.sv */
// Shared constants, calibration types and pipeline structures for pressure compensation.
package ptc_pkg;

	localparam int CAL_W     = 48;
	localparam int NUM_CAL   = 4;
	localparam int CFG_IDX_W = 4;
	localparam int RAW_W     = 20;
	localparam int TC_W      = 16;
	localparam int FINE_W    = 32;
	localparam int FINE_IW   = 24;
	localparam int PA_W      = 20;
	localparam int Q_W       = 36;
	localparam int DM_W      = 39;
	localparam int PROD_W    = 76;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_CAL_A = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_CAL_B = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_CAL_C = 4'd3;

	localparam int FINE_OFFSET = 128000;
	localparam int P_FULL      = 1048576;
	localparam int DIV_MUL     = 3125;
	localparam int PA_MAX      = 1048575;
	localparam int TC_MAX      = 32767;
	localparam int TC_MIN      = -32768;

	// Unpacked calibration words; signed fields are cast at their use.
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} cal_t;

	// Temperature section to pressure term section.
	typedef struct packed {
		logic [FINE_IW-1:0] fine;
		logic [RAW_W-1:0]   raw_p;
	} temp_out_t;

	// Values that ride along the divider; only the overflow flag is set at its entry.
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic               ovf;
		logic [TC_W-1:0]    tc;
		logic [FINE_IW-1:0] fine;
	} side_t;

	// Pressure term section to divider.
	typedef struct packed {
		logic [PROD_W-1:0] num;
		logic [DM_W-1:0]   dm;
		side_t             side;
	} term_out_t;

	// Divider to correction section.
	typedef struct packed {
		logic [Q_W-1:0] q;
		side_t          side;
	} div_out_t;

	// One result word.
	typedef struct packed {
		logic [TC_W-1:0]   temperature_centi;
		logic [FINE_W-1:0] fine_temperature;
		logic [PA_W-1:0]   pressure_pa;
		logic              pressure_invalid;
	} res_t;

	function automatic cal_t unpack_cal(input logic [CAL_W-1:0] c0, input logic [CAL_W-1:0] c1,
			input logic [CAL_W-1:0] c2, input logic [CAL_W-1:0] c3);
		cal_t c;
		c.t1 = c0[15:0];
		c.t2 = c0[31:16];
		c.t3 = c0[47:32];
		c.p1 = c1[15:0];
		c.p2 = c1[31:16];
		c.p3 = c1[47:32];
		c.p4 = c2[15:0];
		c.p5 = c2[31:16];
		c.p6 = c2[47:32];
		c.p7 = c3[15:0];
		c.p8 = c3[31:16];
		c.p9 = c3[47:32];
		return c;
	endfunction

endpackage

/* src/ptc_if.sv */
// Handshake interfaces for the sample, result and configuration channels.
interface ptc_sample_if import ptc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_temperature;
	logic [RAW_W-1:0] raw_pressure;

	modport source (output valid, output raw_temperature, output raw_pressure, input ready);
	modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_result_if import ptc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TC_W-1:0]   temperature_centi;
	logic signed [FINE_W-1:0] fine_temperature;
	logic [PA_W-1:0]          pressure_pa;
	logic                     pressure_invalid;

	modport source (output valid, output temperature_centi, output fine_temperature,
		output pressure_pa, output pressure_invalid, input ready);
	modport sink (input valid, input temperature_centi, input fine_temperature,
		input pressure_pa, input pressure_invalid, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CAL_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/ptc_temp.sv */
// Four-stage fine temperature pipeline.
module ptc_temp import ptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [RAW_W-1:0] raw_t,
	input  logic [RAW_W-1:0] raw_p,
	input  cal_t             cal,
	output logic             out_valid,
	output temp_out_t        out
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [RAW_W-1:0] rp_s1, rp_s2, rp_s3, rp_s4;

	logic signed [18:0] v1_d, v1_s1, h;
	logic signed [35:0] pt2_d, pt2_s2, hh_d, hh_s2, hs;
	logic signed [23:0] v2_d, v2_s3;
	logic signed [39:0] pt3_d, pt3_s3;
	logic signed [23:0] fine_d, fine_s4;

	// Stage arithmetic.
	always_comb begin
		v1_d   = 19'($signed({2'b00, raw_t[19:3]})) - 19'($signed({2'b00, cal.t1, 1'b0}));
		h      = v1_s1 >>> 1;
		pt2_d  = 36'(v1_s1) * 36'($signed(cal.t2));
		hh_d   = 36'(h) * 36'(h);
		hs     = hh_s2 >>> 12;
		v2_d   = 24'(pt2_s2 >>> 11);
		pt3_d  = 40'($signed(hs[22:0])) * 40'($signed(cal.t3));
		fine_d = v2_s3 + 24'(pt3_s3 >>> 14);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (en) begin
			v1_s1   <= v1_d;
			rp_s1   <= raw_p;
			pt2_s2  <= pt2_d;
			hh_s2   <= hh_d;
			rp_s2   <= rp_s1;
			v2_s3   <= v2_d;
			pt3_s3  <= pt3_d;
			rp_s3   <= rp_s2;
			fine_s4 <= fine_d;
			rp_s4   <= rp_s3;
		end
	end

	assign out_valid = v_s4;
	assign out.fine  = fine_s4;
	assign out.raw_p = rp_s4;

endmodule

/* src/ptc_pterm.sv */
// Seven-stage pipeline forming the scaled numerator and divisor of the pressure quotient.
module ptc_pterm import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  temp_out_t in,
	input  cal_t      cal,
	output logic      out_valid,
	output term_out_t out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [TC_W-1:0]    tc_d, tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6, tc_s7;
	logic [FINE_IW-1:0] fn_s1, fn_s2, fn_s3, fn_s4, fn_s5, fn_s6, fn_s7;
	logic [RAW_W-1:0]   rp_s1, rp_s2, rp_s3, rp_s4;

	logic signed [27:0] tc5, tcs;
	logic signed [24:0] vp_d, vp_s1;
	logic signed [49:0] vsq_d, vsq_s2;
	logic signed [40:0] vp5_d, vp5_s2, vp5_s3, vp2_d, vp2_s2, vp2_s3;
	logic signed [65:0] a6_d, a6_s3, a3_d, a3_s3;
	logic signed [63:0] v2_d, v2_s4;
	logic signed [55:0] x_d, x_s4, xh;
	logic signed [45:0] ph_d, ph_s5;
	logic [43:0]        pl_d, pl_s5;
	logic [21:0]        diff;
	logic signed [63:0] num_d, num_s5;
	logic signed [72:0] prod;
	logic signed [39:0] d_d, d_s6;
	logic [63:0]        m_d, m_s6;
	logic               nneg_s6, nneg_s7, dneg;
	logic [PROD_W-1:0]  pm_d, pm_s7;
	logic [DM_W-1:0]    dm_d, dm_s7;
	logic               zero_s7, sgn_s7;

	// Temperature in 0.01 degC with saturation, and the offset fine temperature.
	always_comb begin
		tc5  = 28'($signed(in.fine)) * 28'sd5 + 28'sd128;
		tcs  = tc5 >>> 8;
		if (tcs > 28'(TC_MAX)) begin
			tc_d = 16'(TC_MAX);
		end else if (tcs < 28'(TC_MIN)) begin
			tc_d = 16'(TC_MIN);
		end else begin
			tc_d = tcs[15:0];
		end
		vp_d = 25'($signed(in.fine)) - 25'(FINE_OFFSET);
	end

	// Products, sums and magnitudes of the later stages.
	always_comb begin
		vsq_d = 50'(vp_s1) * 50'(vp_s1);
		vp5_d = 41'(vp_s1) * 41'($signed(cal.p5));
		vp2_d = 41'(vp_s1) * 41'($signed(cal.p2));
		a6_d  = 66'(vsq_s2) * 66'($signed(cal.p6));
		a3_d  = 66'(vsq_s2) * 66'($signed(cal.p3));
		v2_d  = 64'(a6_s3) + (64'(vp5_s3) <<< 17) + (64'($signed(cal.p4)) <<< 35);
		x_d   = 56'(a3_s3 >>> 8) + (56'(vp2_s3) <<< 12) + (56'sd1 <<< 47);
		xh    = x_s4 >>> 27;
		ph_d  = 46'($signed(xh[28:0])) * 46'($signed({1'b0, cal.p1}));
		pl_d  = 44'(x_s4[26:0]) * 44'(cal.p1);
		diff  = 22'(P_FULL) - 22'(rp_s4);
		num_d = (64'($signed({1'b0, diff})) <<< 31) - v2_s4;
		prod  = (73'(ph_s5) <<< 27) + 73'($signed({1'b0, pl_s5}));
		d_d   = 40'(prod >>> 33);
		m_d   = num_s5[63] ? 64'(-num_s5) : 64'(num_s5);
		dneg  = d_s6[39];
		dm_d  = dneg ? 39'(-d_s6) : 39'(d_s6);
		pm_d  = 76'(m_s6) * 76'(DIV_MUL);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1   <= tc_d;
			fn_s1   <= in.fine;
			rp_s1   <= in.raw_p;
			vp_s1   <= vp_d;
			tc_s2   <= tc_s1;
			fn_s2   <= fn_s1;
			rp_s2   <= rp_s1;
			vsq_s2  <= vsq_d;
			vp5_s2  <= vp5_d;
			vp2_s2  <= vp2_d;
			tc_s3   <= tc_s2;
			fn_s3   <= fn_s2;
			rp_s3   <= rp_s2;
			a6_s3   <= a6_d;
			a3_s3   <= a3_d;
			vp5_s3  <= vp5_s2;
			vp2_s3  <= vp2_s2;
			tc_s4   <= tc_s3;
			fn_s4   <= fn_s3;
			rp_s4   <= rp_s3;
			v2_s4   <= v2_d;
			x_s4    <= x_d;
			tc_s5   <= tc_s4;
			fn_s5   <= fn_s4;
			ph_s5   <= ph_d;
			pl_s5   <= pl_d;
			num_s5  <= num_d;
			tc_s6   <= tc_s5;
			fn_s6   <= fn_s5;
			d_s6    <= d_d;
			m_s6    <= m_d;
			nneg_s6 <= num_s5[63];
			tc_s7   <= tc_s6;
			fn_s7   <= fn_s6;
			pm_s7   <= pm_d;
			dm_s7   <= dm_d;
			zero_s7 <= (d_s6 == 40'sd0);
			nneg_s7 <= nneg_s6;
			sgn_s7  <= nneg_s6 ^ dneg;
		end
	end

	assign out_valid      = v_s7;
	assign out.num        = pm_s7;
	assign out.dm         = dm_s7;
	assign out.side.neg   = sgn_s7;
	assign out.side.zero  = zero_s7;
	assign out.side.ovf   = nneg_s7 & 1'b0;
	assign out.side.tc    = tc_s7;
	assign out.side.fine  = fn_s7;

endmodule

/* src/ptc_div.sv */
// Restoring divider, one quotient bit per pipeline stage, behind an overflow check stage.
module ptc_div import ptc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  term_out_t in,
	output logic      out_valid,
	output div_out_t  out
);

	logic            vld_s [0:Q_W];
	logic [DM_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]  w_s   [0:Q_W];
	logic [DM_W-1:0] dm_s  [0:Q_W];
	side_t           sd_s  [0:Q_W];
	side_t           sd_in;

	// Entry: a quotient of 2^36 or more saturates anyway, so only 36 bits are developed.
	always_comb begin
		sd_in     = in.side;
		sd_in.ovf = (in.num[PROD_W-1:Q_W] >= 40'(in.dm));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= Q_W; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= in.num[PROD_W-2:Q_W];
			w_s[0]   <= in.num[Q_W-1:0];
			dm_s[0]  <= in.dm;
			sd_s[0]  <= sd_in;
		end
	end

	// Each stage shifts in one dividend bit and makes one trial subtraction.
	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DM_W:0] trial;
		logic          ge;

		always_comb begin
			trial = {rem_s[k-1], w_s[k-1][Q_W-1]};
			ge    = (trial >= {1'b0, dm_s[k-1]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DM_W'(trial - {1'b0, dm_s[k-1]}) : trial[DM_W-1:0];
				w_s[k]   <= {w_s[k-1][Q_W-2:0], ge};
				dm_s[k]  <= dm_s[k-1];
				sd_s[k]  <= sd_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out.q     = w_s[Q_W];
	assign out.side  = sd_s[Q_W];

endmodule

/* src/ptc_post.sv */
// Five-stage quotient saturation and second-order pressure correction.
module ptc_post import ptc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_out_t in,
	input  cal_t     cal,
	output logic     out_valid,
	output res_t     out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [TC_W-1:0]    tc_s1, tc_s2, tc_s3, tc_s4;
	logic [FINE_IW-1:0] fn_s1, fn_s2, fn_s3, fn_s4;
	logic               z_s1, z_s2, z_s3, z_s4;

	logic [Q_W-1:0]     lim, qs;
	logic signed [36:0] pq_d, pq_s1, pq_s2, pq_s3, pq_s4;
	logic signed [23:0] a_d, a_s2;
	logic signed [52:0] p8_d, p8_s2;
	logic signed [47:0] aa_d, aa_s3;
	logic signed [33:0] v2_d, v2_s3, v2_s4;
	logic signed [63:0] t9_d, t9_s4;
	logic signed [47:0] sum, s, pa;
	res_t               res_d, res_s5;

	// Saturate the quotient magnitude and apply its sign.
	always_comb begin
		lim  = in.side.neg ? (36'd1 << 35) : ((36'd1 << 35) - 36'd1);
		qs   = (in.side.ovf || (in.q > lim)) ? lim : in.q;
		pq_d = in.side.neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
	end

	// Correction products.
	always_comb begin
		a_d  = 24'(pq_s1 >>> 13);
		p8_d = 53'(pq_s1) * 53'($signed(cal.p8));
		aa_d = 48'(a_s2) * 48'(a_s2);
		v2_d = 34'(p8_s2 >>> 19);
		t9_d = 64'(aa_s3) * 64'($signed(cal.p9));
	end

	// Final sum, scaling to pascal and saturation.
	always_comb begin
		sum = 48'(pq_s4) + 48'(t9_s4 >>> 25) + 48'(v2_s4);
		s   = (sum >>> 8) + (48'($signed(cal.p7)) <<< 4);
		pa  = s >>> 8;
		res_d.temperature_centi = tc_s4;
		res_d.fine_temperature  = FINE_W'($signed(fn_s4));
		res_d.pressure_invalid  = z_s4;
		if (z_s4 || pa < 48'sd0) begin
			res_d.pressure_pa = '0;
		end else if (pa > 48'(PA_MAX)) begin
			res_d.pressure_pa = PA_W'(PA_MAX);
		end else begin
			res_d.pressure_pa = pa[PA_W-1:0];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (en) begin
			tc_s1  <= in.side.tc;
			fn_s1  <= in.side.fine;
			z_s1   <= in.side.zero;
			pq_s1  <= pq_d;
			tc_s2  <= tc_s1;
			fn_s2  <= fn_s1;
			z_s2   <= z_s1;
			pq_s2  <= pq_s1;
			a_s2   <= a_d;
			p8_s2  <= p8_d;
			tc_s3  <= tc_s2;
			fn_s3  <= fn_s2;
			z_s3   <= z_s2;
			pq_s3  <= pq_s2;
			aa_s3  <= aa_d;
			v2_s3  <= v2_d;
			tc_s4  <= tc_s3;
			fn_s4  <= fn_s3;
			z_s4   <= z_s3;
			pq_s4  <= pq_s3;
			v2_s4  <= v2_s3;
			t9_s4  <= t9_d;
			res_s5 <= res_d;
		end
	end

	assign out_valid = v_s5;
	assign out       = res_s5;

endmodule

/* src/pressure_temperature_compensation.sv */
// Top level: calibration registers, compensation pipeline and output buffering.
// The block takes one raw temperature and pressure word per clock and returns one
// compensated result per word, in order, after four stages of temperature arithmetic,
// seven of pressure terms, 37 of the one-bit-per-stage quotient divider, five of
// correction and one output register. The rate of one word per cycle holds as long as
// results are taken; an output register plus one skid register let the input keep
// accepting after the result side stalls until a result meets a full output register,
// after which the whole pipeline holds until the skid register drains. Calibration
// registers reset to zero and are written through the configuration channel, which is
// always ready; write them only while no word is in flight. Writes to indexes above the
// last register are dropped.
module pressure_temperature_compensation import ptc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	ptc_sample_if.sink   sample,
	ptc_result_if.source result,
	ptc_cfg_if.sink      cfg
);

	logic [CAL_W-1:0] cal_q [0:NUM_CAL-1];
	cal_t             cal;
	logic             en;
	logic             skid_full_q, out_valid_q;
	res_t             out_q, skid_q;

	logic      t_v, p_v, d_v, r_v;
	temp_out_t t_o;
	term_out_t p_o;
	div_out_t  d_o;
	res_t      r_o;

	// Calibration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CAL; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TEMP_CAL:   cal_q[0] <= cfg.data;
				REG_PRES_CAL_A: cal_q[1] <= cfg.data;
				REG_PRES_CAL_B: cal_q[2] <= cfg.data;
				REG_PRES_CAL_C: cal_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign cal       = unpack_cal(cal_q[0], cal_q[1], cal_q[2], cal_q[3]);

	// The pipeline moves whenever the skid register is free.
	assign en           = !skid_full_q;
	assign sample.ready = en;

	ptc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.raw_t     (sample.raw_temperature),
		.raw_p     (sample.raw_pressure),
		.cal       (cal),
		.out_valid (t_v),
		.out       (t_o)
	);

	ptc_pterm u_pterm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (t_v),
		.in        (t_o),
		.cal       (cal),
		.out_valid (p_v),
		.out       (p_o)
	);

	ptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (p_v),
		.in        (p_o),
		.out_valid (d_v),
		.out       (d_o)
	);

	ptc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_v),
		.in        (d_o),
		.cal       (cal),
		.out_valid (r_v),
		.out       (r_o)
	);

	// Output register and skid register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (result.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= r_v;
		end else if (r_v) begin
			skid_full_q <= 1'b1;
		end
	end

	// Output and skid words.
	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (result.ready) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || result.ready) begin
			out_q <= r_o;
		end else if (r_v) begin
			skid_q <= r_o;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.temperature_centi = $signed(out_q.temperature_centi);
	assign result.fine_temperature  = $signed(out_q.fine_temperature);
	assign result.pressure_pa       = out_q.pressure_pa;
	assign result.pressure_invalid  = out_q.pressure_invalid;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register holds a word while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && result.ready) |=> (out_valid_q && !skid_full_q))
		else $error("skid register did not move to the output register");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.pressure_invalid) |-> (out_q.pressure_pa == '0))
		else $error("invalid pressure word carries a nonzero pressure");
`endif

endmodule
